@@ hw/rtl/clbb_pkg.sv @@
// ----------------------------------------------------------------------------
// clbb_pkg: shared types and constants of the clipped box blur
// Pixel word layout, command codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package clbb_pkg;

  // Channel layout of one stored pixel word.
  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // Field widths of the ports.
  localparam int COORD_IN_W = 9;
  localparam int SIZE_W     = 10;
  localparam int RADIUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  // Signed width of window coordinates; holds every store size up to 4096
  // plus the radius on either side.
  localparam int CW = 14;

  // Largest radius the radius register can express.
  localparam int RADIUS_REG_MAX = 3;

  // Commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

  // Register reset values.
  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 10'd512;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 10'd512;
  localparam logic [RADIUS_W-1:0] RST_BLUR_RADIUS  = 2'd1;

endpackage

@@ hw/rtl/clbb_store.sv @@
// ----------------------------------------------------------------------------
// clbb_store: pixel store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module clbb_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  clbb_pkg::pixel_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output clbb_pkg::pixel_t  rd_data
);

  clbb_pkg::pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/clbb_div.sv @@
// ----------------------------------------------------------------------------
// clbb_div: four-lane restoring divider
// Divides four channel sums by one shared count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clbb_div #(
  parameter int SUMW = 13,
  parameter int CNTW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUMW-1:0]              dividend [clbb_pkg::NUM_CH],
  input  logic [CNTW-1:0]              divisor,
  output logic                         done,
  output logic [clbb_pkg::CH_W-1:0]    quotient [clbb_pkg::NUM_CH]
);

  localparam int STEP_W = $clog2(SUMW + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNTW-1:0]   dvs;
  logic [SUMW-1:0]   acc [clbb_pkg::NUM_CH];
  logic [CNTW-1:0]   rem [clbb_pkg::NUM_CH];

  logic [CNTW:0]     rem_sh   [clbb_pkg::NUM_CH];
  logic              take     [clbb_pkg::NUM_CH];
  logic [CNTW:0]     rem_diff [clbb_pkg::NUM_CH];

  always_comb begin
    for (int c = 0; c < clbb_pkg::NUM_CH; c++) begin
      rem_sh[c]   = {rem[c], acc[c][SUMW-1]};
      take[c]     = rem_sh[c] >= {1'b0, dvs};
      rem_diff[c] = rem_sh[c] - {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUMW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int c = 0; c < clbb_pkg::NUM_CH; c++) begin
        acc[c] <= dividend[c];
        rem[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < clbb_pkg::NUM_CH; c++) begin
        acc[c] <= {acc[c][SUMW-2:0], take[c]};
        rem[c] <= take[c] ? rem_diff[c][CNTW-1:0] : rem_sh[c][CNTW-1:0];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < clbb_pkg::NUM_CH; c++) begin
      quotient[c] = acc[c][clbb_pkg::CH_W-1:0];
    end
  end

endmodule

@@ hw/rtl/clipped_box_blur_rgba.sv @@
// ----------------------------------------------------------------------------
// clipped_box_blur_rgba: box blur over a stored RGBA8888 frame
// Loads pixels into a frame store and answers blur queries from it.
// ----------------------------------------------------------------------------
// A load item (cmd 0) writes one pixel into the frame store in the cycle it
// is accepted and gives no result; loads outside the store are dropped. A
// query item (cmd 1) gives one result item: each channel averaged over the
// square window of half width blur_radius around the pixel, clipped to the
// configured image, divided by the number of in-image window pixels (1 if
// there are none) and truncated. The block handles one item at a time. A
// query walks the window one pixel per cycle through the store's single
// read port, and the four channel sums, each SUMW bits wide (13 bits at
// the default MAX_RADIUS of 2), are then divided by a restoring divider
// that produces one quotient bit per cycle. A finished result waits in the
// output register while the block already takes the next item; a second
// query holds its result until the first one has been taken. The store is
// not cleared after reset: every pixel a query window reaches must have
// been loaded first. Configuration registers should be written only while
// the block is idle.
// ----------------------------------------------------------------------------
module clipped_box_blur_rgba #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_wr_en,
  input  logic [clbb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clbb_pkg::SIZE_W-1:0]          cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [clbb_pkg::COORD_IN_W-1:0]      pixel_x,
  input  logic [clbb_pkg::COORD_IN_W-1:0]      pixel_y,
  input  logic [clbb_pkg::CH_W-1:0]            in_red,
  input  logic [clbb_pkg::CH_W-1:0]            in_green,
  input  logic [clbb_pkg::CH_W-1:0]            in_blue,
  input  logic [clbb_pkg::CH_W-1:0]            in_alpha,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [clbb_pkg::CH_W-1:0]            out_red,
  output logic [clbb_pkg::CH_W-1:0]            out_green,
  output logic [clbb_pkg::CH_W-1:0]            out_blue,
  output logic [clbb_pkg::CH_W-1:0]            out_alpha
);

  localparam int CW    = clbb_pkg::CW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // The radius register cannot exceed three, so neither can the window.
  localparam int RMAX  = (MAX_RADIUS < clbb_pkg::RADIUS_REG_MAX) ?
                         MAX_RADIUS : clbb_pkg::RADIUS_REG_MAX;
  localparam int WIN   = (2 * RMAX + 1) * (2 * RMAX + 1);
  localparam int CNTW  = $clog2(WIN + 1);
  localparam int SUMW  = $clog2(WIN * 255 + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_START,
    S_DIVIDE,
    S_PUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [clbb_pkg::SIZE_W-1:0]   image_width;
  logic [clbb_pkg::SIZE_W-1:0]   image_height;
  logic [clbb_pkg::RADIUS_W-1:0] blur_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= clbb_pkg::RST_IMAGE_WIDTH;
      image_height <= clbb_pkg::RST_IMAGE_HEIGHT;
      blur_radius  <= clbb_pkg::RST_BLUR_RADIUS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        clbb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        clbb_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        clbb_pkg::REG_BLUR_RADIUS:  blur_radius  <= cfg_data[clbb_pkg::RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size, clamped to what the store can hold, and radius, clamped to MAX_RADIUS.
  logic signed [CW-1:0]          img_w;
  logic signed [CW-1:0]          img_h;
  logic [clbb_pkg::RADIUS_W-1:0] radius_eff;
  logic signed [CW-1:0]          radius_s;

  always_comb begin
    img_w = ({4'b0, image_width} > CW'(MAX_WIDTH)) ?
            CW'(MAX_WIDTH) : $signed({4'b0, image_width});
    img_h = ({4'b0, image_height} > CW'(MAX_HEIGHT)) ?
            CW'(MAX_HEIGHT) : $signed({4'b0, image_height});
    radius_eff = (32'(blur_radius) > MAX_RADIUS) ?
                 clbb_pkg::RADIUS_W'(MAX_RADIUS) : blur_radius;
    radius_s = $signed({{(CW - clbb_pkg::RADIUS_W){1'b0}}, radius_eff});
  end

  // Input handshake and load path. Loads go straight to the store.
  logic                 in_fire;
  logic signed [CW-1:0] px_s;
  logic signed [CW-1:0] py_s;
  logic                 load_in_store;
  logic                 st_wr_en;
  logic [AW-1:0]        st_wr_addr;
  clbb_pkg::pixel_t     st_wr_data;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign px_s     = $signed({5'b0, pixel_x});
  assign py_s     = $signed({5'b0, pixel_y});

  always_comb begin
    load_in_store = (px_s < CW'(MAX_WIDTH)) && (py_s < CW'(MAX_HEIGHT));
    st_wr_en      = in_fire && (cmd == clbb_pkg::CMD_LOAD) && load_in_store;
    st_wr_addr    = AW'(32'(pixel_y) * 32'(MAX_WIDTH) + 32'(pixel_x));
    st_wr_data[clbb_pkg::CH_RED]   = in_red;
    st_wr_data[clbb_pkg::CH_GREEN] = in_green;
    st_wr_data[clbb_pkg::CH_BLUE]  = in_blue;
    st_wr_data[clbb_pkg::CH_ALPHA] = in_alpha;
  end

  // Window walk: one window position per cycle, row by row. Positions that
  // fall outside the image issue no read and add nothing.
  logic signed [CW-1:0] xx;
  logic signed [CW-1:0] yy;
  logic signed [CW-1:0] x_lo;
  logic signed [CW-1:0] x_hi;
  logic signed [CW-1:0] y_hi;
  logic                 in_img;
  logic                 st_rd_en;
  logic [AW-1:0]        st_rd_addr;
  clbb_pkg::pixel_t     st_rd_data;
  logic                 rd_pending;

  always_comb begin
    in_img = (xx >= 0) && (xx < img_w) && (yy >= 0) && (yy < img_h);
    st_rd_en   = (state == S_WALK) && in_img;
    st_rd_addr = AW'(32'(yy) * 32'(MAX_WIDTH) + 32'(xx));
  end

  clbb_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Channel sums and pixel count.
  logic [SUMW-1:0] sum [clbb_pkg::NUM_CH];
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] divisor;

  assign divisor = (count == '0) ? CNTW'(1) : count;

  logic                      div_start;
  logic                      div_done;
  logic [clbb_pkg::CH_W-1:0] quotient [clbb_pkg::NUM_CH];

  assign div_start = (state == S_START);

  clbb_div #(
    .SUMW (SUMW),
    .CNTW (CNTW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer with the read-pending flag and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= st_rd_en;
      // A new result may replace one that is taken in the same cycle.
      if ((state == S_PUT) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire && (cmd == clbb_pkg::CMD_QUERY)) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if ((xx == x_hi) && (yy == y_hi)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN:  state <= S_START;
        S_START:  state <= S_DIVIDE;
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          // The previous result must be taken before this one replaces it.
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: walk coordinates, accumulators, output payload.
  always_ff @(posedge clk) begin
    if (in_fire && (cmd == clbb_pkg::CMD_QUERY)) begin
      x_lo  <= px_s - radius_s;
      x_hi  <= px_s + radius_s;
      y_hi  <= py_s + radius_s;
      xx    <= px_s - radius_s;
      yy    <= py_s - radius_s;
      count <= '0;
      for (int c = 0; c < clbb_pkg::NUM_CH; c++) begin
        sum[c] <= '0;
      end
    end else begin
      if (state == S_WALK) begin
        if (xx == x_hi) begin
          xx <= x_lo;
          yy <= yy + CW'(1);
        end else begin
          xx <= xx + CW'(1);
        end
      end
      if (rd_pending) begin
        count <= count + CNTW'(1);
        for (int c = 0; c < clbb_pkg::NUM_CH; c++) begin
          sum[c] <= sum[c] + SUMW'(st_rd_data[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_PUT) && (!out_valid || out_ready)) begin
      out_red   <= quotient[clbb_pkg::CH_RED];
      out_green <= quotient[clbb_pkg::CH_GREEN];
      out_blue  <= quotient[clbb_pkg::CH_BLUE];
      out_alpha <= quotient[clbb_pkg::CH_ALPHA];
    end
  end

endmodule
